>>> design/gjs_pkg.sv
// shared constants, types and command/status structs of the gauss-jordan solver
`default_nettype none

package gjs_pkg;

  localparam int MAX_ORDER = 4;
  localparam int MAX_RHS   = 4;
  localparam int VAL_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ACOL_W    = IDX_W + 1;
  localparam int ADDR_W    = IDX_W + ACOL_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int CFG_W     = 3;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int QUO_W     = VAL_W + 1;
  localparam int DCNT_W    = $clog2(VAL_W + 1);

  localparam logic signed [VAL_W-1:0] ONE_Q = VAL_W'(64'd1 << FRAC_W);
  localparam logic signed [VAL_W-1:0] VMAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VMIN  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [2*VAL_W-1:0] HALF_Q = (2*VAL_W)'(1) << (FRAC_W - 1);

  // register index codes, taken from paddr bit 2
  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_RHS  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SR_RD,
    S_SR_CMP,
    S_SW_RD,
    S_SW_W0,
    S_SW_W1,
    S_PV_RD,
    S_PV_CHK,
    S_DIV,
    S_OP_RD,
    S_OP_MUL,
    S_OP_RND,
    S_OP_WR,
    S_TT_RD,
    S_TT_LD,
    S_US_CHK,
    S_OUT_RD,
    S_OUT_LD,
    S_SING
  } state_e;

  typedef enum logic [1:0] {
    WS_LOAD,
    WS_RD0,
    WS_RD1,
    WS_OP
  } wsel_e;

  typedef enum logic {
    M_SCALE,
    M_ELIM
  } mode_e;

  typedef enum logic {
    PH_ROW,
    PH_COL
  } phase_e;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] ra0;
    logic [ADDR_W-1:0] ra1;
    logic              we;
    wsel_e             wsel;
    logic [ADDR_W-1:0] wa;
    logic              big_clr;
    logic              big_ld;
    logic              div_start;
    logic              f_ld_rd;
    logic              sub_one;
    logic              sub_zero;
    logic              op_sub;
    logic              out_ld;
    logic              out_sing;
    logic              out_kind;
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic              out_end;
  } cmd_t;

  typedef struct packed {
    logic ge;
    logic piv_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> design/gjs_if.sv
// request and result channel interfaces of the gauss-jordan solver
`default_nettype none

interface gjs_in_if;
  import gjs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [VAL_W-1:0] value;
  logic                    final_load;
  modport source (output valid, func, row, col, value, final_load, input ready);
  modport sink (input valid, func, row, col, value, final_load, output ready);
endinterface

interface gjs_out_if;
  import gjs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    out_kind;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    status;
  logic                    end_of_run;
  modport source (output valid, out_kind, out_row, out_col, out_value, status, end_of_run,
                  input ready);
  modport sink (input valid, out_kind, out_row, out_col, out_value, status, end_of_run,
                output ready);
endinterface

`default_nettype wire

>>> design/gjs_div.sv
// iterative reciprocal unit: saturated 2^32 / divisor, one quotient bit a cycle
`default_nettype none

module gjs_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [gjs_pkg::VAL_W-1:0] divisor_i,
  output logic                             done_o,
  output logic signed [gjs_pkg::VAL_W-1:0] quot_o
);
  import gjs_pkg::*;

  logic              busy_q, done_q, neg_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [VAL_W-1:0]  d_q, rem_q;
  logic [QUO_W-1:0]  quo_q;
  logic [VAL_W:0]    rem_sh, rem_sub;
  logic              fits;

  // dividend is a single one at bit VAL_W
  assign rem_sh  = {rem_q, (cnt_q == DCNT_W'(VAL_W))};
  assign rem_sub = rem_sh - {1'b0, d_q};
  assign fits    = rem_sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(VAL_W);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q   <= divisor_i[VAL_W-1] ? VAL_W'(-divisor_i) : divisor_i;
      neg_q <= divisor_i[VAL_W-1];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  always_comb begin
    if (neg_q) begin
      quot_o = (quo_q > {1'b0, VMIN}) ? VMIN : VAL_W'(-quo_q[VAL_W-1:0]);
    end else begin
      quot_o = (quo_q > {1'b0, VMAX}) ? VMAX : quo_q[VAL_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

>>> design/gjs_dpath.sv
// datapath: matrix store, pivot compare, fixed-point multiply-subtract, result register
`default_nettype none

module gjs_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gjs_pkg::cmd_t                    cmd_i,
  output gjs_pkg::status_t                 status_o,
  input  logic signed [gjs_pkg::VAL_W-1:0] load_value_i,
  gjs_out_if.source                        res_o
);
  import gjs_pkg::*;

  logic signed [VAL_W-1:0] mem_q [MEM_DEPTH];
  logic signed [VAL_W-1:0] rd0_q, rd1_q, f_q, qm_q, wdata, x_op, y_op, op_res, qsat;
  logic [VAL_W-1:0]        big_q, mag;
  logic signed [2*VAL_W-1:0] prod_q, rnd;
  logic signed [2*VAL_W-FRAC_W-1:0] shr;
  logic [VAL_W:0]          diff;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_quot;

  logic                    out_valid_q, out_kind_q, out_stat_q, out_end_q;
  logic [IDX_W-1:0]        out_row_q, out_col_q;
  logic signed [VAL_W-1:0] out_val_q;

  gjs_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .divisor_i(rd0_q),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  always_comb begin
    case (cmd_i.wsel)
      WS_LOAD: wdata = load_value_i;
      WS_RD0:  wdata = rd0_q;
      WS_RD1:  wdata = rd1_q;
      default: wdata = op_res;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[cmd_i.wa] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd0_q <= mem_q[cmd_i.ra0];
      rd1_q <= mem_q[cmd_i.ra1];
    end
  end

  // pivot magnitude search
  assign mag = rd0_q[VAL_W-1] ? VAL_W'(-rd0_q) : rd0_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.big_clr) begin
      big_q <= '0;
    end else if (cmd_i.big_ld) begin
      big_q <= mag;
    end
  end

  // multiply factor: reciprocal of the pivot or the row multiplier
  always_ff @(posedge clk_i) begin
    if (div_done) begin
      f_q <= div_quot;
    end else if (cmd_i.f_ld_rd) begin
      f_q <= rd0_q;
    end
  end

  // product, then round and saturate, then subtract
  assign x_op = cmd_i.sub_one ? ONE_Q : rd0_q;
  assign y_op = cmd_i.sub_zero ? '0 : rd1_q;
  assign rnd  = prod_q + $signed(HALF_Q);
  assign shr  = rnd[2*VAL_W-1:FRAC_W];

  always_comb begin
    if (&shr[2*VAL_W-FRAC_W-1:VAL_W-1] || ~|shr[2*VAL_W-FRAC_W-1:VAL_W-1]) begin
      qsat = shr[VAL_W-1:0];
    end else begin
      qsat = shr[2*VAL_W-FRAC_W-1] ? VMIN : VMAX;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= x_op * f_q;
    qm_q   <= qsat;
  end

  assign diff = {y_op[VAL_W-1], y_op} - {qm_q[VAL_W-1], qm_q};

  always_comb begin
    if (!cmd_i.op_sub) begin
      op_res = qm_q;
    end else if (diff[VAL_W] != diff[VAL_W-1]) begin
      op_res = diff[VAL_W] ? VMIN : VMAX;
    end else begin
      op_res = diff[VAL_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_kind_q <= cmd_i.out_kind;
      out_row_q  <= cmd_i.out_row;
      out_col_q  <= cmd_i.out_col;
      out_val_q  <= cmd_i.out_sing ? '0 : rd0_q;
      out_stat_q <= cmd_i.out_sing;
      out_end_q  <= cmd_i.out_end;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.out_kind   = out_kind_q;
  assign res_o.out_row    = out_row_q;
  assign res_o.out_col    = out_col_q;
  assign res_o.out_value  = out_val_q;
  assign res_o.status     = out_stat_q;
  assign res_o.end_of_run = out_end_q;

  assign status_o.ge       = mag >= big_q;
  assign status_o.piv_zero = rd0_q == '0;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || res_o.ready;

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_ld |-> status_o.out_free)
    else $error("result register overwritten");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> rd0_q != '0)
    else $error("reciprocal started on zero pivot");

  a_factor_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |=> f_q == $past(div_quot))
    else $error("reciprocal not captured");

endmodule

`default_nettype wire

>>> design/gjs_ctrl.sv
// controller: config registers, load handling and elimination sequencer
`default_nettype none

module gjs_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gjs_pkg::PADDR_W-1:0]  paddr,
  input  logic [gjs_pkg::PDATA_W-1:0]  pwdata,
  output logic [gjs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  gjs_in_if.sink                       req_i,
  input  gjs_pkg::status_t             status_i,
  output gjs_pkg::cmd_t                cmd_o
);
  import gjs_pkg::*;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  phase_e            phase_q, phase_d;
  logic [CFG_W-1:0]  size_q, rhs_q;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d, irow_q, irow_d, icol_q, icol_d;
  logic [IDX_W-1:0]  n1_q, n1_d, m1_q, m1_d;
  logic [ACOL_W-1:0] ac_q, ac_d, ac_next;
  logic [MAX_ORDER-1:0] used_q, used_d;
  logic [IDX_W-1:0]  row_log_q [MAX_ORDER];
  logic [IDX_W-1:0]  row_log_d [MAX_ORDER];
  logic [IDX_W-1:0]  col_log_q [MAX_ORDER];
  logic [IDX_W-1:0]  col_log_d [MAX_ORDER];
  logic [IDX_W-1:0]  rlog, clog, sel_row, sel_col, lim;
  logic [IDX_W:0]    j_first, j_nxt;
  logic              col_last, cand, take, stage_end, us_next, srch_last, cfg_wr;
  logic [ADDR_W-1:0] sw_a0, sw_a1, op_a1;

  function automatic logic [IDX_W-1:0] clamp_m1(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] t;
    t = (v == '0) ? CFG_W'(1) : ((v > hi) ? hi : v);
    t = t - 1'b1;
    return t[IDX_W-1:0];
  endfunction

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CFG_W'(MAX_ORDER);
      rhs_q  <= CFG_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[PADDR_W-1])
        REG_SIZE: size_q <= pwdata[CFG_W-1:0];
        REG_RHS:  rhs_q  <= pwdata[CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1])
      REG_SIZE: prdata = PDATA_W'(size_q);
      REG_RHS:  prdata = PDATA_W'(rhs_q);
      default:  prdata = '0;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);

  // shared sequencing helpers
  assign rlog     = row_log_q[i_q];
  assign clog     = col_log_q[i_q];
  assign col_last = ac_q[ACOL_W-1] && (ac_q[IDX_W-1:0] == m1_q);
  assign ac_next  = (!ac_q[ACOL_W-1] && (ac_q[IDX_W-1:0] == n1_q)) ?
                    {1'b1, {IDX_W{1'b0}}} : ac_q + 1'b1;
  assign j_first  = (icol_q == '0) ? (IDX_W+1)'(1) : '0;
  always_comb begin
    j_nxt = {1'b0, j_q} + 1'b1;
    if (j_nxt == {1'b0, icol_q}) begin
      j_nxt = j_nxt + 1'b1;
    end
  end
  assign cand      = !used_q[j_q] && !used_q[ac_q[IDX_W-1:0]];
  assign take      = cand && status_i.ge;
  assign sel_row   = take ? j_q : irow_q;
  assign sel_col   = take ? ac_q[IDX_W-1:0] : icol_q;
  assign srch_last = (ac_q[IDX_W-1:0] == n1_q) && (j_q == n1_q);
  assign lim       = ac_q[ACOL_W-1] ? m1_q : n1_q;

  assign sw_a0 = (phase_q == PH_ROW) ? {irow_q, ac_q} : {j_q, 1'b0, rlog};
  assign sw_a1 = (phase_q == PH_ROW) ? {icol_q, ac_q} : {j_q, 1'b0, clog};
  assign op_a1 = (mode_q == M_SCALE) ? {icol_q, ac_q} : {j_q, ac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_SCALE;
      phase_q <= PH_ROW;
      i_q     <= '0;
      j_q     <= '0;
      ac_q    <= '0;
      irow_q  <= '0;
      icol_q  <= '0;
      n1_q    <= '0;
      m1_q    <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      phase_q <= phase_d;
      i_q     <= i_d;
      j_q     <= j_d;
      ac_q    <= ac_d;
      irow_q  <= irow_d;
      icol_q  <= icol_d;
      n1_q    <= n1_d;
      m1_q    <= m1_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_log_q <= row_log_d;
    col_log_q <= col_log_d;
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    phase_d   = phase_q;
    i_d       = i_q;
    j_d       = j_q;
    ac_d      = ac_q;
    irow_d    = irow_q;
    icol_d    = icol_q;
    n1_d      = n1_q;
    m1_d      = m1_q;
    used_d    = used_q;
    row_log_d = row_log_q;
    col_log_d = col_log_q;
    stage_end = 1'b0;
    us_next   = 1'b0;
    cmd_o          = '0;
    cmd_o.wsel     = WS_LOAD;
    cmd_o.sub_one  = (mode_q == M_SCALE) && (ac_q == {1'b0, icol_q});
    cmd_o.sub_zero = (mode_q == M_ELIM) && (ac_q == {1'b0, icol_q});
    cmd_o.op_sub   = (mode_q == M_ELIM);

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_o.we   = 1'b1;
          cmd_o.wsel = WS_LOAD;
          cmd_o.wa   = {req_i.row, req_i.func, req_i.col};
          if (req_i.final_load) begin
            n1_d   = clamp_m1(size_q, CFG_W'(MAX_ORDER));
            m1_d   = clamp_m1(rhs_q, CFG_W'(MAX_RHS));
            i_d    = '0;
            j_d    = '0;
            ac_d   = '0;
            used_d = '0;
            cmd_o.big_clr = 1'b1;
            state_d = S_SR_RD;
          end
        end
      end
      S_SR_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.ra0   = {j_q, 1'b0, ac_q[IDX_W-1:0]};
        state_d     = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (take) begin
          cmd_o.big_ld = 1'b1;
          irow_d       = sel_row;
          icol_d       = sel_col;
        end
        if (srch_last) begin
          used_d[sel_col]  = 1'b1;
          row_log_d[i_q]   = sel_row;
          col_log_d[i_q]   = sel_col;
          ac_d    = '0;
          phase_d = PH_ROW;
          state_d = (sel_row != sel_col) ? S_SW_RD : S_PV_RD;
        end else if (ac_q[IDX_W-1:0] == n1_q) begin
          j_d     = j_q + 1'b1;
          ac_d    = '0;
          state_d = S_SR_RD;
        end else begin
          ac_d    = ac_q + 1'b1;
          state_d = S_SR_RD;
        end
      end
      S_SW_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.ra0   = sw_a0;
        cmd_o.ra1   = sw_a1;
        state_d     = S_SW_W0;
      end
      S_SW_W0: begin
        cmd_o.we   = 1'b1;
        cmd_o.wa   = sw_a0;
        cmd_o.wsel = WS_RD1;
        state_d    = S_SW_W1;
      end
      S_SW_W1: begin
        cmd_o.we   = 1'b1;
        cmd_o.wa   = sw_a1;
        cmd_o.wsel = WS_RD0;
        if (phase_q == PH_ROW) begin
          if (col_last) begin
            state_d = S_PV_RD;
          end else begin
            ac_d    = ac_next;
            state_d = S_SW_RD;
          end
        end else if (j_q == n1_q) begin
          us_next = 1'b1;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_SW_RD;
        end
      end
      S_PV_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.ra0   = {icol_q, 1'b0, icol_q};
        state_d     = S_PV_CHK;
      end
      S_PV_CHK: begin
        if (status_i.piv_zero) begin
          state_d = S_SING;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          mode_d  = M_SCALE;
          ac_d    = '0;
          state_d = S_OP_RD;
        end
      end
      S_OP_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.ra0   = {icol_q, ac_q};
        cmd_o.ra1   = op_a1;
        state_d     = S_OP_MUL;
      end
      S_OP_MUL: state_d = S_OP_RND;
      S_OP_RND: state_d = S_OP_WR;
      S_OP_WR: begin
        cmd_o.we   = 1'b1;
        cmd_o.wa   = op_a1;
        cmd_o.wsel = WS_OP;
        if (!col_last) begin
          ac_d    = ac_next;
          state_d = S_OP_RD;
        end else if (mode_q == M_SCALE) begin
          if (j_first <= {1'b0, n1_q}) begin
            j_d     = j_first[IDX_W-1:0];
            state_d = S_TT_RD;
          end else begin
            stage_end = 1'b1;
          end
        end else if (j_nxt <= {1'b0, n1_q}) begin
          j_d     = j_nxt[IDX_W-1:0];
          state_d = S_TT_RD;
        end else begin
          stage_end = 1'b1;
        end
      end
      S_TT_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.ra0   = {j_q, 1'b0, icol_q};
        state_d     = S_TT_LD;
      end
      S_TT_LD: begin
        cmd_o.f_ld_rd = 1'b1;
        mode_d  = M_ELIM;
        ac_d    = '0;
        state_d = S_OP_RD;
      end
      S_US_CHK: begin
        if (rlog != clog) begin
          phase_d = PH_COL;
          j_d     = '0;
          state_d = S_SW_RD;
        end else begin
          us_next = 1'b1;
        end
      end
      S_OUT_RD: begin
        if (status_i.out_free) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.ra0   = {j_q, ac_q};
          state_d     = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        cmd_o.out_ld   = 1'b1;
        cmd_o.out_kind = ac_q[ACOL_W-1];
        cmd_o.out_row  = j_q;
        cmd_o.out_col  = ac_q[IDX_W-1:0];
        cmd_o.out_end  = col_last && (j_q == n1_q);
        state_d        = S_OUT_RD;
        if (ac_q[IDX_W-1:0] == lim) begin
          if (j_q == n1_q) begin
            if (ac_q[ACOL_W-1]) begin
              state_d = S_IDLE;
            end else begin
              j_d  = '0;
              ac_d = {1'b1, {IDX_W{1'b0}}};
            end
          end else begin
            j_d  = j_q + 1'b1;
            ac_d = {ac_q[ACOL_W-1], {IDX_W{1'b0}}};
          end
        end else begin
          ac_d = ac_q + 1'b1;
        end
      end
      S_SING: begin
        if (status_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_sing = 1'b1;
          cmd_o.out_end  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // stage finished: next pivot search, or start undoing column swaps
    if (stage_end) begin
      if (i_q == n1_q) begin
        state_d = S_US_CHK;
      end else begin
        i_d  = i_q + 1'b1;
        j_d  = '0;
        ac_d = '0;
        cmd_o.big_clr = 1'b1;
        state_d = S_SR_RD;
      end
    end

    // column swap of one stage undone: step back or start emitting
    if (us_next) begin
      if (i_q == '0) begin
        j_d     = '0;
        ac_d    = '0;
        state_d = S_OUT_RD;
      end else begin
        i_d     = i_q - 1'b1;
        state_d = S_US_CHK;
      end
    end
  end

  a_used_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SR_CMP && srch_last) |=>
      $countones(used_q) == $past($countones(used_q)) + 1)
    else $error("pivot column not marked used");

  a_row_swap_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SW_RD && phase_q == PH_ROW) |-> irow_q != icol_q)
    else $error("row swap without distinct rows");

  a_elim_not_pivot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OP_WR && mode_q == M_ELIM) |-> j_q != icol_q)
    else $error("pivot row eliminated");

endmodule

`default_nettype wire

>>> design/gauss_jordan_full_pivot_solver.sv
// top level of the gauss-jordan full-pivot solver
//
// usage: each request on req_i loads one entry, func 0 into the coefficient
// matrix A, func 1 into the right-hand-side matrix B, at (row, col). a
// request with final_load set stores its entry and then starts the solve
// on the first size_in_use rows/cols of A and rhs_columns columns of B
// (both set over the apb port, clamped to 1..4). the solve runs on a
// single-port-write, dual-read store of A and B: per stage a pivot scan,
// a row swap when the pivot row and column differ, a bit-serial
// reciprocal, a scale pass and (n-1) elimination passes through the
// shared multiply-subtract unit; after the last stage the column swaps
// are undone, last stage first. the run time is set by the one store
// write port and the shared multiplier. results leave on res_o: n*n
// inverse entries then n*m solution entries, end_of_run on the last. a
// zero pivot gives a single result with status 1. res_o has its own
// output register: when the receiver stalls the solver waits, and after
// the last result is loaded it takes new requests at once. reset returns
// to idle with n=4, m=1; the stored matrices are not cleared.
`default_nettype none

module gauss_jordan_full_pivot_solver (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gjs_pkg::PADDR_W-1:0]  paddr,
  input  logic [gjs_pkg::PDATA_W-1:0]  pwdata,
  output logic [gjs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  gjs_in_if.sink                       req_i,
  gjs_out_if.source                    res_o
);
  import gjs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer, config registers and request handshake
  gjs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_i),
    .status_i(status),
    .cmd_o   (cmd)
  );

  // store, arithmetic and result register
  gjs_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .load_value_i(req_i.value),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// self-checking bench for the gauss-jordan full-pivot solver
`default_nettype none

module tb_top;
  import gjs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 40;

  // one load request as the stimulus side sees it
  typedef struct {
    logic                    func;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    final_load;
    bit                      drain_first; // hold off until all results are back
  } load_t;

  // one result entry the solver must emit
  typedef struct {
    logic                    kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    status;
    logic                    last;
  } entry_t;

  localparam logic FUNC_COEF = 1'b0;
  localparam logic FUNC_RHS  = 1'b1;
  localparam logic KIND_INV  = 1'b0;
  localparam logic KIND_SOL  = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_SING   = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;

  gjs_in_if  req_ch ();
  gjs_out_if res_ch ();

  gauss_jordan_full_pivot_solver u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch.sink),
    .res_o   (res_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------
  // solver model: its own copy of the stores and the two registers
  // ---------------------------------------------------------------
  longint  coef_m [16];
  longint  rhs_m  [16];
  int      piv_cnt [4];
  int      row_log [4];
  int      col_log [4];
  logic [CFG_W-1:0] order_reg = 3'd4;
  logic [CFG_W-1:0] rhs_reg   = 3'd1;

  load_t  pending_loads [$];
  entry_t solver_results [$];
  int     err_count = 0;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // q16.16 product, rounded half up by floor division
  function automatic longint q_mul(longint a, longint b);
    longint p, q;
    p = a * b + 64'sd32768;
    q = p / 64'sd65536;
    if ((p % 64'sd65536) != 0 && p < 0) q = q - 1;
    return sat32(q);
  endfunction

  function automatic longint q_abs(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic void swap_coef(int a, int b);
    longint t;
    t = coef_m[a]; coef_m[a] = coef_m[b]; coef_m[b] = t;
  endfunction

  function automatic void swap_rhs(int a, int b);
    longint t;
    t = rhs_m[a]; rhs_m[a] = rhs_m[b]; rhs_m[b] = t;
  endfunction

  // full-pivot elimination in place, 0 when singular
  function automatic bit eliminate(int n, int m);
    int irow, icol;
    longint big, g, pinv, tt;
    irow = 0;
    icol = 0;
    for (int i = 0; i < 4; i++) piv_cnt[i] = 0;
    for (int i = 0; i < n; i++) begin
      big = 0;
      for (int j = 0; j < n; j++) begin
        if (piv_cnt[j] == 1) continue;
        for (int k = 0; k < n; k++) begin
          if (piv_cnt[k] == 0) begin
            g = q_abs(coef_m[j*4+k]);
            if (g >= big) begin
              big = g; irow = j; icol = k;
            end
          end else if (piv_cnt[k] > 1) begin
            return 1'b0;
          end
        end
      end
      if (piv_cnt[icol] < 3) piv_cnt[icol]++;
      if (irow != icol) begin
        for (int j = 0; j < n; j++) swap_coef(irow*4+j, icol*4+j);
        for (int j = 0; j < m; j++) swap_rhs(irow*4+j, icol*4+j);
      end
      row_log[i] = irow;
      col_log[i] = icol;
      if (coef_m[icol*5] == 0) return 1'b0;
      pinv = sat32(64'sd4294967296 / coef_m[icol*5]);
      coef_m[icol*5] = 64'sd65536;
      for (int j = 0; j < n; j++) coef_m[icol*4+j] = q_mul(coef_m[icol*4+j], pinv);
      for (int j = 0; j < m; j++) rhs_m[icol*4+j] = q_mul(rhs_m[icol*4+j], pinv);
      for (int j = 0; j < n; j++) begin
        if (j == icol) continue;
        tt = coef_m[j*4+icol];
        coef_m[j*4+icol] = 0;
        for (int k = 0; k < n; k++)
          coef_m[j*4+k] = sat32(coef_m[j*4+k] - q_mul(coef_m[icol*4+k], tt));
        for (int k = 0; k < m; k++)
          rhs_m[j*4+k] = sat32(rhs_m[j*4+k] - q_mul(rhs_m[icol*4+k], tt));
      end
    end
    // undo the column swaps, last stage first
    for (int i = n - 1; i >= 0; i--)
      if (row_log[i] != col_log[i])
        for (int k = 0; k < n; k++) swap_coef(k*4+row_log[i], k*4+col_log[i]);
    return 1'b1;
  endfunction

  function automatic void push_result(logic kind, int r, int c, longint v,
                                      logic st, logic last);
    entry_t e;
    e.kind   = kind;
    e.row    = r[IDX_W-1:0];
    e.col    = c[IDX_W-1:0];
    e.value  = v[VAL_W-1:0];
    e.status = st;
    e.last   = last;
    solver_results.push_back(e);
  endfunction

  // apply one accepted load and queue whatever results it causes
  function automatic void predict_load(load_t ld);
    int n, m, cnt, total;
    if (ld.func == FUNC_COEF) coef_m[ld.row*4+ld.col] = longint'(ld.value);
    else                      rhs_m[ld.row*4+ld.col]  = longint'(ld.value);
    if (!ld.final_load) return;
    n = (order_reg < 1) ? 1 : (order_reg > 4) ? 4 : int'(order_reg);
    m = (rhs_reg < 1) ? 1 : (rhs_reg > 4) ? 4 : int'(rhs_reg);
    if (!eliminate(n, m)) begin
      push_result(KIND_INV, 0, 0, 0, ST_SING, 1'b1);
      return;
    end
    total = n*n + n*m;
    cnt = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        cnt++;
        push_result(KIND_INV, i, j, coef_m[i*4+j], ST_OK, cnt == total);
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < m; j++) begin
        cnt++;
        push_result(KIND_SOL, i, j, rhs_m[i*4+j], ST_OK, cnt == total);
      end
  endfunction

  // ---------------------------------------------------------------
  // request driver: bursts with random gaps, model updated on accept
  // ---------------------------------------------------------------
  int burst_left, gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid      <= 1'b0;
      req_ch.func       <= FUNC_COEF;
      req_ch.row        <= '0;
      req_ch.col        <= '0;
      req_ch.value      <= '0;
      req_ch.final_load <= 1'b0;
      burst_left        <= 0;
      gap_left          <= 0;
    end else begin
      // prediction first, so a drain hold below sees the new results
      if (req_ch.valid && req_ch.ready) begin
        load_t acc;
        acc.func        = req_ch.func;
        acc.row         = req_ch.row;
        acc.col         = req_ch.col;
        acc.value       = req_ch.value;
        acc.final_load  = req_ch.final_load;
        acc.drain_first = 1'b0;
        predict_load(acc);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          req_ch.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (pending_loads.size() == 0 ||
                     (pending_loads[0].drain_first && solver_results.size() != 0)) begin
          req_ch.valid <= 1'b0;
        end else begin
          load_t nx;
          nx = pending_loads.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.func       <= nx.func;
          req_ch.row        <= nx.row;
          req_ch.col        <= nx.col;
          req_ch.value      <= nx.value;
          req_ch.final_load <= nx.final_load;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            // end of burst: next burst length and the gap before it
            burst_left <= $urandom_range(0, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // result monitor: stall pattern shifts between free, random and slow
  // ---------------------------------------------------------------
  int cyc;
  int stall_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      cyc          <= 0;
      stall_mode   <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: res_ch.ready <= (cyc % 8 == 0);
      endcase
      if (res_ch.valid && res_ch.ready) begin
        if (solver_results.size() == 0) begin
          $error("result with none expected: kind %0d row %0d col %0d value %0h",
                 res_ch.out_kind, res_ch.out_row, res_ch.out_col, res_ch.out_value);
          err_count <= err_count + 1;
        end else begin
          entry_t e;
          bit bad;
          e = solver_results.pop_front();
          bad = 1'b0;
          if (res_ch.out_kind !== e.kind) begin
            $error("out_kind expected %0h got %0h", e.kind, res_ch.out_kind); bad = 1'b1;
          end
          if (res_ch.out_row !== e.row) begin
            $error("out_row expected %0h got %0h", e.row, res_ch.out_row); bad = 1'b1;
          end
          if (res_ch.out_col !== e.col) begin
            $error("out_col expected %0h got %0h", e.col, res_ch.out_col); bad = 1'b1;
          end
          if (res_ch.out_value !== e.value) begin
            $error("out_value expected %0h got %0h", e.value, res_ch.out_value); bad = 1'b1;
          end
          if (res_ch.status !== e.status) begin
            $error("status expected %0h got %0h", e.status, res_ch.status); bad = 1'b1;
          end
          if (res_ch.end_of_run !== e.last) begin
            $error("end_of_run expected %0h got %0h", e.last, res_ch.end_of_run);
            bad = 1'b1;
          end
          if (bad) err_count <= err_count + 1;
        end
      end
    end
  end

  // watchdog: the solve itself can run with no handshake on either channel
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------
  int load_total = 0;

  function automatic void add_load(logic func, int r, int c, logic [31:0] v,
                                   logic fin, bit drain);
    load_t ld;
    ld.func        = func;
    ld.row         = r[IDX_W-1:0];
    ld.col         = c[IDX_W-1:0];
    ld.value       = v;
    ld.final_load  = fin;
    ld.drain_first = drain;
    pending_loads.push_back(ld);
    load_total++;
  endfunction

  // mostly small q16.16 values, some raw words and zeros
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2:    return $urandom;
      default: return 32'($signed($urandom_range(0, 1048576)) - 524288);
    endcase
  endfunction

  task automatic apb_write(logic reg_idx, logic [2:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {29'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_SIZE) order_reg = val;
    else                     rhs_reg   = val;
  endtask

  // block until every queued load is taken and every result is back
  task automatic wait_idle();
    while (pending_loads.size() != 0 || req_ch.valid) @(posedge clk_i);
    while (solver_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_shape(logic [2:0] n, logic [2:0] m);
    wait_idle();
    apb_write(REG_SIZE, n);
    apb_write(REG_RHS, m);
  endtask

  initial begin
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset shape n=4 m=1, every store entry written once,
    // diagonal-heavy coefficients, full-scale extremes on the rhs
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        add_load(FUNC_COEF, r, c, (r == c) ? 32'h0004_0000 + 32'(r) * 32'h1_0000
                                           : 32'(c - r) * 32'h0000_8000, 1'b0, 1'b0);
    add_load(FUNC_RHS, 0, 1, 32'h7fff_ffff, 1'b0, 1'b0);
    add_load(FUNC_RHS, 1, 1, 32'h8000_0000, 1'b0, 1'b0);
    add_load(FUNC_RHS, 2, 1, 32'hffff_ffff, 1'b0, 1'b0);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        if (c != 1) add_load(FUNC_RHS, r, c, 32'(r + 1) * 32'h0001_0000, 1'b0, 1'b0);
    add_load(FUNC_RHS, 3, 1, 32'h0000_0001, 1'b1, 1'b0);
    // solve again on the reduced stores, sender held until results drain
    add_load(FUNC_RHS, 0, 0, 32'h0002_0000, 1'b1, 1'b1);

    // all four rhs columns, n at its top
    set_shape(3'd4, 3'd4);
    add_load(FUNC_COEF, 3, 3, 32'h7fff_ffff, 1'b1, 1'b0);

    // singular: order clamped up from zero, zero pivot; then a most-negative pivot and clamped shapes
    set_shape(3'd0, 3'd7);
    add_load(FUNC_COEF, 0, 0, 32'h0000_0000, 1'b1, 1'b0);
    set_shape(3'd1, 3'd1);
    add_load(FUNC_COEF, 0, 0, 32'h8000_0000, 1'b1, 1'b0);
    set_shape(3'd7, 3'd0);
    add_load(FUNC_COEF, 1, 2, 32'h0003_0000, 1'b1, 1'b0);

    // random phases: new shape, a handful of loads, then a solve
    while (load_total < 360) begin
      int nsz, kind;
      set_shape(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      nsz  = (order_reg < 1) ? 1 : (order_reg > 4) ? 4 : int'(order_reg);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // zero block: singular result if the final load leaves the block all zero
        for (int r = 0; r < nsz; r++)
          for (int c = 0; c < nsz; c++) add_load(FUNC_COEF, r, c, 32'd0, 1'b0, 1'b0);
      end else if (kind < 6) begin
        // fresh system with a mostly heavy diagonal
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            add_load(FUNC_COEF, r, c, (r == c && $urandom_range(0, 3) != 0)
                     ? 32'h0006_0000 + 32'($urandom_range(0, 65535)) : pick_value(),
                     1'b0, 1'b0);
        for (int k = $urandom_range(0, 6); k > 0; k--)
          add_load(FUNC_RHS, $urandom_range(0, 3), $urandom_range(0, 3), pick_value(),
                   1'b0, 1'b0);
      end else begin
        // scattered updates on top of the previous contents
        for (int k = $urandom_range(0, 8); k > 0; k--)
          add_load(1'($urandom_range(0, 1)), $urandom_range(0, 3), $urandom_range(0, 3),
                   pick_value(), 1'b0, 1'b0);
      end
      add_load(1'($urandom_range(0, 1)), $urandom_range(0, 3), $urandom_range(0, 3),
               pick_value(), 1'b1, $urandom_range(0, 3) == 0);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
